// ----- rtl/fba_pkg.sv -----
// Shared types, codes and the lowest-clear-bit helper of the frame bitmap allocator.
package fba_pkg;

	localparam int WORD_BITS = 32;
	localparam int POS_BITS = 5;
	localparam int FRAME_BITS = 15;
	localparam int COUNT_BITS = 16;
	localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = 16'd32768;

	typedef logic [1:0] kind_t;
	typedef logic [FRAME_BITS-1:0] frame_t;
	typedef logic [1:0] status_t;
	typedef logic [WORD_BITS-1:0] map_word_t;
	typedef logic [POS_BITS-1:0] bit_pos_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	localparam kind_t KIND_ALLOC = 2'd0;
	localparam kind_t KIND_FREE = 2'd1;
	localparam kind_t KIND_TEST = 2'd2;
	localparam kind_t KIND_NOP = 2'd3;

	localparam status_t STAT_OK = 2'd0;
	localparam status_t STAT_NO_FREE = 2'd1;
	localparam status_t STAT_RANGE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	// Isolates the lowest clear bit and encodes its position.
	function automatic bit_pos_t lowest_clear_pos(input map_word_t word);
		map_word_t inv;
		map_word_t iso;
		bit_pos_t pos;
		inv = ~word;
		iso = inv & (~inv + map_word_t'(1));
		pos = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (iso[j]) begin
				pos = pos | bit_pos_t'(j);
			end
		end
		return pos;
	endfunction

endpackage

// ----- rtl/fba_req_if.sv -----
// Request channel carrying the operation kind and frame index.
interface fba_req_if;
	logic valid;
	logic ready;
	fba_pkg::kind_t kind;
	fba_pkg::frame_t frame_index;

	modport source (output valid, output kind, output frame_index, input ready);
	modport sink (input valid, input kind, input frame_index, output ready);
endinterface

// ----- rtl/fba_rsp_if.sv -----
// Response channel carrying the frame, used flag and status of one request.
interface fba_rsp_if;
	logic valid;
	logic ready;
	fba_pkg::frame_t frame_out;
	logic used;
	fba_pkg::status_t status;

	modport source (output valid, output frame_out, output used, output status, input ready);
	modport sink (input valid, input frame_out, input used, input status, output ready);
endinterface

// ----- rtl/frame_bitmap_allocator.sv -----
// Frame bitmap allocator: sequencer, bit unit and bitmap memory.
// An allocate checks one bitmap word at a time (READ, EVAL) until it finds a clear bit, scanning
// at most MAX_FRAMES / 32 words; the result word is then loaded in DONE, and the next request is
// taken after that. A free or test reads one word, out of range or no operation none; a held
// result word stalls. After reset a clearing pass writes all MAX_FRAMES / 32 words, reserved
// frames used; no request is accepted during it, while frame_count writes are taken at any time.
module frame_bitmap_allocator #(
	parameter int unsigned MAX_FRAMES = 32768,
	parameter int unsigned RESERVED_FRAMES = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input fba_pkg::count_t cfg_wdata,
	fba_req_if.sink req,
	fba_rsp_if.source rsp
);

	localparam int MAP_WORDS = MAX_FRAMES / 32;
	localparam int WA = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int SW = ((WA > 11) ? WA : 11) + 1;
	localparam int EW = ($clog2(MAX_FRAMES + 1) > 16) ? $clog2(MAX_FRAMES + 1) : 16;
	localparam int RES_EFF = (RESERVED_FRAMES < MAX_FRAMES) ? RESERVED_FRAMES : MAX_FRAMES;
	localparam int RES_WORDS = RES_EFF / 32;
	localparam int RES_REM = RES_EFF % 32;
	localparam fba_pkg::map_word_t PART_MASK =
		(RES_REM == 0) ? '0 : ~(fba_pkg::FULL_WORD << RES_REM);

	fba_pkg::state_t state_q, state_d;
	logic [WA-1:0] clr_q;
	logic [WA-1:0] addr_q;
	fba_pkg::count_t frame_count_q;
	fba_pkg::kind_t kind_q;
	fba_pkg::frame_t idx_q;
	fba_pkg::frame_t res_frame_q;
	logic res_used_q;
	fba_pkg::status_t res_status_q;
	logic out_valid_q;
	fba_pkg::frame_t out_frame_q;
	logic out_used_q;
	fba_pkg::status_t out_status_q;

	fba_pkg::count_t eff_count;
	logic [10:0] scan_words;
	logic in_range;
	logic scan_last;
	logic word_full;
	fba_pkg::bit_pos_t clear_pos;
	fba_pkg::map_word_t rd_word;
	fba_pkg::map_word_t init_word;
	fba_pkg::map_word_t sel_mask;
	logic ram_we;
	logic [WA-1:0] ram_waddr;
	fba_pkg::map_word_t ram_wdata;
	logic out_load;

	fba_map_ram #(
		.DEPTH(MAP_WORDS),
		.AW(WA)
	) u_map (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(rd_word)
	);

	assign eff_count = (EW'(frame_count_q) > EW'(MAX_FRAMES)) ? 16'(MAX_FRAMES) : frame_count_q;
	assign scan_words = eff_count[15:5];
	assign in_range = fba_pkg::count_t'(req.frame_index) < eff_count;
	assign scan_last = (SW'(addr_q) + SW'(1)) == SW'(scan_words);
	assign word_full = rd_word == fba_pkg::FULL_WORD;
	assign clear_pos = fba_pkg::lowest_clear_pos(rd_word);
	assign sel_mask = fba_pkg::map_word_t'(1) << idx_q[4:0];

	always_comb begin
		if (32'(clr_q) < 32'(RES_WORDS)) begin
			init_word = fba_pkg::FULL_WORD;
		end else if (32'(clr_q) == 32'(RES_WORDS)) begin
			init_word = PART_MASK;
		end else begin
			init_word = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fba_pkg::ST_CLEAR: begin
				if (clr_q == WA'(MAP_WORDS - 1)) begin
					state_d = fba_pkg::ST_IDLE;
				end
			end
			fba_pkg::ST_IDLE: begin
				if (req.valid) begin
					case (req.kind)
						fba_pkg::KIND_ALLOC: begin
							state_d = (scan_words == '0) ? fba_pkg::ST_DONE : fba_pkg::ST_READ;
						end
						fba_pkg::KIND_FREE, fba_pkg::KIND_TEST: begin
							state_d = in_range ? fba_pkg::ST_READ : fba_pkg::ST_DONE;
						end
						default: begin
							state_d = fba_pkg::ST_DONE;
						end
					endcase
				end
			end
			fba_pkg::ST_READ: begin
				state_d = fba_pkg::ST_EVAL;
			end
			fba_pkg::ST_EVAL: begin
				if (kind_q == fba_pkg::KIND_ALLOC && word_full && !scan_last) begin
					state_d = fba_pkg::ST_READ;
				end else begin
					state_d = fba_pkg::ST_DONE;
				end
			end
			fba_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = fba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fba_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = rd_word;
		req.ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			fba_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = init_word;
			end
			fba_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			fba_pkg::ST_EVAL: begin
				if (kind_q == fba_pkg::KIND_ALLOC && !word_full) begin
					ram_we = 1'b1;
					ram_wdata = rd_word | (fba_pkg::map_word_t'(1) << clear_pos);
				end else if (kind_q == fba_pkg::KIND_FREE) begin
					ram_we = 1'b1;
					ram_wdata = rd_word & ~sel_mask;
				end
			end
			fba_pkg::ST_DONE: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fba_pkg::ST_CLEAR;
			clr_q <= '0;
			frame_count_q <= fba_pkg::COUNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fba_pkg::ST_CLEAR) begin
				clr_q <= clr_q + WA'(1);
			end
			if (cfg_we) begin
				frame_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fba_pkg::ST_IDLE && req.valid) begin
			kind_q <= req.kind;
			idx_q <= req.frame_index;
			res_frame_q <= req.frame_index;
			res_used_q <= 1'b0;
			res_status_q <= fba_pkg::STAT_OK;
			if (req.kind == fba_pkg::KIND_ALLOC) begin
				addr_q <= '0;
				if (scan_words == '0) begin
					res_frame_q <= '0;
					res_status_q <= fba_pkg::STAT_NO_FREE;
				end
			end else begin
				addr_q <= WA'(req.frame_index >> 5);
				if (req.kind != fba_pkg::KIND_NOP && !in_range) begin
					res_status_q <= fba_pkg::STAT_RANGE;
				end
			end
		end
		if (state_q == fba_pkg::ST_EVAL) begin
			case (kind_q)
				fba_pkg::KIND_ALLOC: begin
					if (!word_full) begin
						res_frame_q <= fba_pkg::frame_t'({addr_q, clear_pos});
					end else if (scan_last) begin
						res_frame_q <= '0;
						res_status_q <= fba_pkg::STAT_NO_FREE;
					end else begin
						addr_q <= addr_q + WA'(1);
					end
				end
				fba_pkg::KIND_TEST: begin
					res_used_q <= rd_word[idx_q[4:0]];
				end
				default: begin
					res_used_q <= 1'b0;
				end
			endcase
		end
		if (out_load) begin
			out_frame_q <= res_frame_q;
			out_used_q <= res_used_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.frame_out = out_frame_q;
	assign rsp.used = out_used_q;
	assign rsp.status = out_status_q;

endmodule

// ----- rtl/fba_map_ram.sv -----
// Single-port-write, registered-read memory holding the frame bitmap words.
module fba_map_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input fba_pkg::map_word_t wdata,
	input logic [AW-1:0] raddr,
	output fba_pkg::map_word_t rdata
);

	fba_pkg::map_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
